// ===== sv/face_tangent_basis_assert.svh =====
// ---------------------------------------------------------------------------
// face_tangent_basis assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef FACE_TANGENT_BASIS_ASSERT_SVH
`define FACE_TANGENT_BASIS_ASSERT_SVH

// same-cycle implication
`define FTB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ftb: same-cycle check failed");

// next-cycle implication
`define FTB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ftb: next-cycle check failed");

`endif

// ===== sv/ftb_pkg.sv =====
// ---------------------------------------------------------------------------
// ftb_pkg
// Widths, word types and arithmetic helpers of the tangent basis pipeline.
// ---------------------------------------------------------------------------
package ftb_pkg;

  localparam int CW   = 16;
  localparam int NW   = 16;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int DW   = PW + 1;
  localparam int THW  = 24;
  localparam int TL   = 24;
  localparam int BL   = 20;
  localparam int PL   = 24;
  localparam int TW   = TL + 1;
  localparam int BW   = BL + 1;
  localparam int PSH  = 28;
  localparam int NTW  = NW + TW;
  localparam int NDW  = NTW + 2;
  localparam int NPW  = NW + NDW;
  localparam int PRW  = NPW + 1;
  localparam int KW   = $clog2(PRW + 1);
  localparam int SW   = PL + 1;
  localparam int XPW  = NW + SW;
  localparam int CRW  = XPW + 1;
  localparam int HPW  = CRW + BW;
  localparam int HDW  = HPW + 2;
  localparam int SQW  = 2 * PL + 2;
  localparam int LW   = PL + 1;
  localparam int FRAC = 14;
  localparam int OW   = 16;
  localparam int QW   = FRAC + 1;
  localparam int REMW = PL + FRAC + 2;

  localparam int SQS    = 2;
  localparam int QPS    = 3;
  localparam int FR_STG = 6;
  localparam int OG_STG = 10;
  localparam int SQ_STG = (LW + SQS - 1) / SQS;
  localparam int DV_STG = (QW + QPS - 1) / QPS;
  localparam int NS     = FR_STG + OG_STG + SQ_STG + DV_STG + 1;

  localparam logic [THW-1:0] THR_RESET = THW'(168);
  localparam logic [TW-1:0]  T_DEF     = TW'(1) << (TL - 1);
  localparam logic [BW-1:0]  B_DEF     = BW'(1) << (BL - 1);
  localparam int             NMAX      = 2 ** (NW - 1) - 1;

  typedef struct packed {
    logic [3*CW-1:0] corner0_position;
    logic [3*CW-1:0] corner1_position;
    logic [3*CW-1:0] corner_last_position;
    logic [2*CW-1:0] corner0_texcoord;
    logic [2*CW-1:0] corner1_texcoord;
    logic [2*CW-1:0] corner_last_texcoord;
    logic [3*CW-1:0] face_normal;
  } in_word_t;

  typedef struct packed {
    logic signed [OW-1:0] tangent_x;
    logic signed [OW-1:0] tangent_y;
    logic signed [OW-1:0] tangent_z;
    logic                 handedness_negative;
    logic                 degenerate_uv;
  } out_word_t;

  typedef struct packed {
    logic [2:0][TW-1:0] t;
    logic [2:0][BW-1:0] b;
    logic [2:0][NW-1:0] n;
    logic               degen;
  } fr_t;

  typedef struct packed {
    logic [2:0][PL-1:0] pm;
    logic [2:0]         ps;
    logic [SQW-1:0]     lensq;
    logic               hand;
    logic               degen;
  } og_t;

  typedef struct packed {
    logic [2:0][PL-1:0] pm;
    logic [2:0]         ps;
    logic [LW-1:0]      len;
    logic               hand;
    logic               degen;
  } sq_t;

  typedef struct packed {
    logic [2:0][QW-1:0] q;
    logic [2:0]         ps;
    logic               zero;
    logic               hand;
    logic               degen;
  } dv_t;

  typedef struct packed {
    logic [SQW-1:0] x;
    logic [SQW-1:0] r;
  } sq_acc_t;

  typedef struct packed {
    logic [REMW-1:0] rem;
    logic [QW-1:0]   q;
  } dv_acc_t;

  function automatic logic signed [CW-1:0] comp(input logic [3*CW-1:0] v, input int s);
    return v[s*CW +: CW];
  endfunction

  function automatic logic signed [NW-1:0] sat_n(input logic signed [CW-1:0] x);
    if (int'(x) > NMAX) return NW'(NMAX);
    if (int'(x) < -NMAX - 1) return NW'(-NMAX - 1);
    return NW'(x);
  endfunction

  // right shift that brings the widest magnitude below 2^lim
  function automatic logic [KW-1:0] shr_amt(input logic [PRW-1:0] m, input int lim);
    int bl;
    bl = 0;
    for (int i = 0; i < PRW; i++) begin
      if (m[i]) bl = i + 1;
    end
    if (bl > lim) return KW'(bl - lim);
    return '0;
  endfunction

  function automatic sq_acc_t sq_step(input sq_acc_t a, input int j);
    logic [SQW:0] bt;
    logic [SQW:0] tr;
    sq_acc_t      o;
    bt = (SQW + 1)'(1) << (2 * (LW - 1 - j));
    tr = {1'b0, a.r} + bt;
    o  = a;
    if ({1'b0, a.x} >= tr) begin
      o.x = SQW'({1'b0, a.x} - tr);
      o.r = SQW'(({1'b0, a.r} >> 1) + bt);
    end else begin
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic dv_acc_t dv_step(input dv_acc_t a, input logic [LW-1:0] len,
                                      input int i);
    logic [REMW-1:0] sub;
    dv_acc_t         o;
    sub = REMW'(len) << i;
    o   = a;
    if (a.rem >= sub) begin
      o.rem  = a.rem - sub;
      o.q[i] = 1'b1;
    end
    return o;
  endfunction

endpackage

// ===== sv/ftb_front.sv =====
// ---------------------------------------------------------------------------
// ftb_front
// Edges, uv determinant, raw tangent and binormal, degeneracy and shrink.
// ---------------------------------------------------------------------------
module ftb_front (
  input  logic                         clk_i,
  input  logic [ftb_pkg::FR_STG-1:0]   en_i,
  input  logic [ftb_pkg::THW-1:0]      thr_i,
  input  ftb_pkg::in_word_t            in_i,
  output ftb_pkg::fr_t                 fr_o
);
  import ftb_pkg::*;

  logic signed [NW-1:0] n_q [FR_STG][3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [EW-1:0] t1u_q, t1v_q, t2u_q, t2v_q;
  logic signed [PW-1:0] da_q, db_q;
  logic signed [PW-1:0] ta_q [3];
  logic signed [PW-1:0] tb_q [3];
  logic signed [PW-1:0] ba_q [3];
  logic signed [PW-1:0] bb_q [3];
  logic signed [DW-1:0] det_q;
  logic signed [DW-1:0] tr_q [3];
  logic signed [DW-1:0] br_q [3];
  logic [DW-1:0]        tm4_q [3];
  logic [DW-1:0]        bm4_q [3];
  logic [2:0]           ts4_q, bs4_q;
  logic                 dg4_q;
  logic [DW-1:0]        tm5_q [3];
  logic [DW-1:0]        bm5_q [3];
  logic [2:0]           ts5_q, bs5_q;
  logic                 dg5_q;
  logic [KW-1:0]        kt_q, kb_q;
  logic signed [TW-1:0] t_q [3];
  logic signed [BW-1:0] b_q [3];
  logic                 dg6_q;

  logic signed [CW-1:0] u0, v0, u1, v1, u2, v2;
  logic [DW-1:0]        dmag;
  logic [TL-1:0]        tsh [3];
  logic [BL-1:0]        bsh [3];

  always_comb begin
    u0   = comp({{CW{1'b0}}, in_i.corner0_texcoord}, 0);
    v0   = comp({{CW{1'b0}}, in_i.corner0_texcoord}, 1);
    u1   = comp({{CW{1'b0}}, in_i.corner1_texcoord}, 0);
    v1   = comp({{CW{1'b0}}, in_i.corner1_texcoord}, 1);
    u2   = comp({{CW{1'b0}}, in_i.corner_last_texcoord}, 0);
    v2   = comp({{CW{1'b0}}, in_i.corner_last_texcoord}, 1);
    dmag = det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
    for (int i = 0; i < 3; i++) begin
      tsh[i] = TL'(tm5_q[i] >> kt_q);
      bsh[i] = BL'(bm5_q[i] >> kb_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        e1_q[i]   <= EW'(comp(in_i.corner1_position, i)) - EW'(comp(in_i.corner0_position, i));
        e2_q[i]   <= EW'(comp(in_i.corner_last_position, i))
                     - EW'(comp(in_i.corner0_position, i));
        n_q[0][i] <= sat_n(comp(in_i.face_normal, i));
      end
      t1u_q <= EW'(u1) - EW'(u0);
      t1v_q <= EW'(v1) - EW'(v0);
      t2u_q <= EW'(u2) - EW'(u0);
      t2v_q <= EW'(v2) - EW'(v0);
    end
    for (int s = 1; s < FR_STG; s++) begin
      if (en_i[s]) n_q[s] <= n_q[s-1];
    end
    if (en_i[1]) begin
      da_q <= t1u_q * t2v_q;
      db_q <= t2u_q * t1v_q;
      for (int i = 0; i < 3; i++) begin
        ta_q[i] <= t2v_q * e1_q[i];
        tb_q[i] <= t1v_q * e2_q[i];
        ba_q[i] <= t1u_q * e2_q[i];
        bb_q[i] <= t2u_q * e1_q[i];
      end
    end
    if (en_i[2]) begin
      det_q <= DW'(da_q) - DW'(db_q);
      for (int i = 0; i < 3; i++) begin
        tr_q[i] <= DW'(ta_q[i]) - DW'(tb_q[i]);
        br_q[i] <= DW'(ba_q[i]) - DW'(bb_q[i]);
      end
    end
    if (en_i[3]) begin
      dg4_q <= dmag < DW'(thr_i);
      for (int i = 0; i < 3; i++) begin
        tm4_q[i] <= tr_q[i][DW-1] ? DW'(-tr_q[i]) : DW'(tr_q[i]);
        bm4_q[i] <= br_q[i][DW-1] ? DW'(-br_q[i]) : DW'(br_q[i]);
        ts4_q[i] <= tr_q[i][DW-1] ^ det_q[DW-1];
        bs4_q[i] <= br_q[i][DW-1] ^ det_q[DW-1];
      end
    end
    if (en_i[4]) begin
      kt_q  <= shr_amt(PRW'(tm4_q[0] | tm4_q[1] | tm4_q[2]), TL);
      kb_q  <= shr_amt(PRW'(bm4_q[0] | bm4_q[1] | bm4_q[2]), BL);
      tm5_q <= tm4_q;
      bm5_q <= bm4_q;
      ts5_q <= ts4_q;
      bs5_q <= bs4_q;
      dg5_q <= dg4_q;
    end
    if (en_i[5]) begin
      dg6_q <= dg5_q;
      for (int i = 0; i < 3; i++) begin
        if (dg5_q) begin
          t_q[i] <= (i == 0) ? T_DEF : '0;
          b_q[i] <= (i == 1) ? B_DEF : '0;
        end else begin
          t_q[i] <= ts5_q[i] ? -TW'(tsh[i]) : TW'(tsh[i]);
          b_q[i] <= bs5_q[i] ? -BW'(bsh[i]) : BW'(bsh[i]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fr_o.t[i] = t_q[i];
      fr_o.b[i] = b_q[i];
      fr_o.n[i] = n_q[FR_STG-1][i];
    end
    fr_o.degen = dg6_q;
  end

endmodule

// ===== sv/ftb_ortho.sv =====
// ---------------------------------------------------------------------------
// ftb_ortho
// Gram-Schmidt against the normal, shrink, squared length and handedness.
// ---------------------------------------------------------------------------
module ftb_ortho (
  input  logic                       clk_i,
  input  logic [ftb_pkg::OG_STG-1:0] en_i,
  input  ftb_pkg::fr_t               fr_i,
  output ftb_pkg::og_t               og_o
);
  import ftb_pkg::*;

  localparam int NST = 6;
  localparam int BST = 8;
  localparam int TST = 3;
  localparam int PB  = 5;

  logic signed [NW-1:0]  n_q [NST][3];
  logic signed [BW-1:0]  b_q [BST][3];
  logic signed [TW-1:0]  t_q [TST][3];
  logic [OG_STG-1:0]     dg_q;
  logic signed [NTW-1:0] nt_q [3];
  logic signed [NDW-1:0] d_q;
  logic signed [NPW-1:0] nd_q [3];
  logic [PRW-1:0]        pm3_q [3];
  logic [2:0]            ps3_q;
  logic [PRW-1:0]        pm4_q [3];
  logic [2:0]            ps4_q;
  logic [KW-1:0]         kp_q;
  logic [PL-1:0]         pp_q [OG_STG-PB][3];
  logic [2:0]            ps_q [OG_STG-PB];
  logic [2*PL-1:0]       sq_q [3];
  logic signed [XPW-1:0] xa_q [3];
  logic signed [XPW-1:0] xb_q [3];
  logic [SQW-1:0]        ls_q [3];
  logic signed [CRW-1:0] c_q [3];
  logic signed [HPW-1:0] hp_q [3];
  logic                  hand_q;

  logic signed [PRW-1:0] pr [3];
  logic signed [SW-1:0]  psg [3];
  logic signed [HDW-1:0] dot;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i]  = (PRW'(t_q[2][i]) <<< PSH) - PRW'(nd_q[i]);
      psg[i] = ps_q[0][i] ? -SW'(pp_q[0][i]) : SW'(pp_q[0][i]);
    end
    dot = HDW'(hp_q[0]) + HDW'(hp_q[1]) + HDW'(hp_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dg_q[0] <= fr_i.degen;
      for (int i = 0; i < 3; i++) begin
        n_q[0][i] <= $signed(fr_i.n[i]);
        b_q[0][i] <= $signed(fr_i.b[i]);
        t_q[0][i] <= $signed(fr_i.t[i]);
        nt_q[i]   <= $signed(fr_i.n[i]) * $signed(fr_i.t[i]);
      end
    end
    for (int s = 1; s < OG_STG; s++) begin
      if (en_i[s]) dg_q[s] <= dg_q[s-1];
    end
    for (int s = 1; s < NST; s++) begin
      if (en_i[s]) n_q[s] <= n_q[s-1];
    end
    for (int s = 1; s < BST; s++) begin
      if (en_i[s]) b_q[s] <= b_q[s-1];
    end
    for (int s = 1; s < TST; s++) begin
      if (en_i[s]) t_q[s] <= t_q[s-1];
    end
    if (en_i[1]) d_q <= NDW'(nt_q[0]) + NDW'(nt_q[1]) + NDW'(nt_q[2]);
    if (en_i[2]) begin
      for (int i = 0; i < 3; i++) nd_q[i] <= n_q[1][i] * d_q;
    end
    if (en_i[3]) begin
      for (int i = 0; i < 3; i++) begin
        pm3_q[i] <= pr[i][PRW-1] ? PRW'(-pr[i]) : PRW'(pr[i]);
        ps3_q[i] <= pr[i][PRW-1];
      end
    end
    if (en_i[4]) begin
      kp_q  <= shr_amt(pm3_q[0] | pm3_q[1] | pm3_q[2], PL);
      pm4_q <= pm3_q;
      ps4_q <= ps3_q;
    end
    if (en_i[PB]) begin
      for (int i = 0; i < 3; i++) pp_q[0][i] <= PL'(pm4_q[i] >> kp_q);
      ps_q[0] <= ps4_q;
    end
    for (int s = 1; s < OG_STG - PB; s++) begin
      if (en_i[PB+s]) begin
        pp_q[s] <= pp_q[s-1];
        ps_q[s] <= ps_q[s-1];
      end
    end
    if (en_i[6]) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= pp_q[0][i] * pp_q[0][i];
      xa_q[0] <= n_q[5][1] * psg[2];
      xb_q[0] <= n_q[5][2] * psg[1];
      xa_q[1] <= n_q[5][2] * psg[0];
      xb_q[1] <= n_q[5][0] * psg[2];
      xa_q[2] <= n_q[5][0] * psg[1];
      xb_q[2] <= n_q[5][1] * psg[0];
    end
    if (en_i[7]) begin
      ls_q[0] <= SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);
      for (int i = 0; i < 3; i++) c_q[i] <= CRW'(xa_q[i]) - CRW'(xb_q[i]);
    end
    if (en_i[8]) begin
      ls_q[1] <= ls_q[0];
      for (int i = 0; i < 3; i++) hp_q[i] <= c_q[i] * b_q[7][i];
    end
    if (en_i[9]) begin
      ls_q[2] <= ls_q[1];
      hand_q  <= dot[HDW-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) og_o.pm[i] = pp_q[OG_STG-PB-1][i];
    og_o.ps    = ps_q[OG_STG-PB-1];
    og_o.lensq = ls_q[2];
    og_o.hand  = hand_q;
    og_o.degen = dg_q[OG_STG-1];
  end

endmodule

// ===== sv/ftb_sqrt.sv =====
// ---------------------------------------------------------------------------
// ftb_sqrt
// Pipelined integer square root, two result bits per stage.
// ---------------------------------------------------------------------------
module ftb_sqrt (
  input  logic                       clk_i,
  input  logic [ftb_pkg::SQ_STG-1:0] en_i,
  input  ftb_pkg::og_t               og_i,
  output ftb_pkg::sq_t               sq_o
);
  import ftb_pkg::*;

  sq_acc_t            acc_q [SQ_STG];
  sq_acc_t            acc_d [SQ_STG];
  logic [2:0][PL-1:0] pm_q [SQ_STG];
  logic [2:0]         ps_q [SQ_STG];
  logic [SQ_STG-1:0]  hand_q, dg_q;

  always_comb begin
    sq_acc_t a;
    for (int s = 0; s < SQ_STG; s++) begin
      if (s == 0) begin
        a.x = og_i.lensq;
        a.r = '0;
      end else begin
        a = acc_q[s-1];
      end
      for (int k = 0; k < SQS; k++) begin
        if (s * SQS + k < LW) a = sq_step(a, s * SQS + k);
      end
      acc_d[s] = a;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < SQ_STG; s++) begin
      if (en_i[s]) begin
        acc_q[s]  <= acc_d[s];
        pm_q[s]   <= (s == 0) ? og_i.pm    : pm_q[s-1];
        ps_q[s]   <= (s == 0) ? og_i.ps    : ps_q[s-1];
        hand_q[s] <= (s == 0) ? og_i.hand  : hand_q[s-1];
        dg_q[s]   <= (s == 0) ? og_i.degen : dg_q[s-1];
      end
    end
  end

  assign sq_o.pm    = pm_q[SQ_STG-1];
  assign sq_o.ps    = ps_q[SQ_STG-1];
  assign sq_o.len   = LW'(acc_q[SQ_STG-1].r);
  assign sq_o.hand  = hand_q[SQ_STG-1];
  assign sq_o.degen = dg_q[SQ_STG-1];

endmodule

// ===== sv/ftb_div.sv =====
// ---------------------------------------------------------------------------
// ftb_div
// Three-lane pipelined rounding divide of the components by the length.
// ---------------------------------------------------------------------------
module ftb_div (
  input  logic                       clk_i,
  input  logic [ftb_pkg::DV_STG-1:0] en_i,
  input  ftb_pkg::sq_t               sq_i,
  output ftb_pkg::dv_t               dv_o
);
  import ftb_pkg::*;

  dv_acc_t           acc_q [DV_STG][3];
  dv_acc_t           acc_d [DV_STG][3];
  logic [LW-1:0]     len_q [DV_STG];
  logic [2:0]        ps_q [DV_STG];
  logic [DV_STG-1:0] hand_q, dg_q;

  always_comb begin
    dv_acc_t       a;
    logic [LW-1:0] len;
    for (int s = 0; s < DV_STG; s++) begin
      len = (s == 0) ? sq_i.len : len_q[s-1];
      for (int i = 0; i < 3; i++) begin
        if (s == 0) begin
          a.rem = (REMW'(sq_i.pm[i]) << FRAC) + REMW'(sq_i.len >> 1);
          a.q   = '0;
        end else begin
          a = acc_q[s-1][i];
        end
        for (int k = 0; k < QPS; k++) begin
          if (s * QPS + k < QW) a = dv_step(a, len, QW - 1 - (s * QPS + k));
        end
        acc_d[s][i] = a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DV_STG; s++) begin
      if (en_i[s]) begin
        acc_q[s]  <= acc_d[s];
        len_q[s]  <= (s == 0) ? sq_i.len   : len_q[s-1];
        ps_q[s]   <= (s == 0) ? sq_i.ps    : ps_q[s-1];
        hand_q[s] <= (s == 0) ? sq_i.hand  : hand_q[s-1];
        dg_q[s]   <= (s == 0) ? sq_i.degen : dg_q[s-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) dv_o.q[i] = acc_q[DV_STG-1][i].q;
    dv_o.ps    = ps_q[DV_STG-1];
    dv_o.zero  = len_q[DV_STG-1] == '0;
    dv_o.hand  = hand_q[DV_STG-1];
    dv_o.degen = dg_q[DV_STG-1];
  end

endmodule

// ===== sv/face_tangent_basis.sv =====
// ---------------------------------------------------------------------------
// face_tangent_basis
// Tangent-space basis of one triangle face: unit Q1.14 tangent, handedness
// and degenerate-uv flag.
// ---------------------------------------------------------------------------
//   channel | signals                                | moves
//   in      | in_valid_i / in_ready_o / in_data_i    | one face word
//   out     | out_valid_o / out_ready_i / out_data_o | one tangent word
//   cfg     | cfg_we_i / cfg_data_i                  | uv determinant bound
//
// One word per cycle while out_ready_i is high; the 13-stage square root
// and 5-stage divide follow 16 arithmetic stages and feed one output
// register. Every stage has its own valid bit and advances when it is empty
// or the stage after it advances, so bubbles close up under a stall.
// Reset clears the valid bits and sets the bound to 168.
// ---------------------------------------------------------------------------
module face_tangent_basis (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  ftb_pkg::in_word_t       in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output ftb_pkg::out_word_t      out_data_o,
  input  logic                    cfg_we_i,
  input  logic [ftb_pkg::THW-1:0] cfg_data_i
);
  import ftb_pkg::*;

  localparam int OG0 = FR_STG;
  localparam int SQ0 = OG0 + OG_STG;
  localparam int DV0 = SQ0 + SQ_STG;

  logic [NS-1:0]  v_q, v_d;
  logic [NS:0]    rdy;
  logic [THW-1:0] thr_q;
  fr_t            fr;
  og_t            og;
  sq_t            sq;
  dv_t            dv;
  out_word_t      out_d, out_q;

  always_comb begin
    rdy[NS] = out_ready_i;
    for (int s = NS - 1; s >= 0; s--) rdy[s] = !v_q[s] || rdy[s+1];
    v_d[0] = rdy[0] ? in_valid_i : v_q[0];
    for (int s = 1; s < NS; s++) v_d[s] = rdy[s] ? v_q[s-1] : v_q[s];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      thr_q <= THR_RESET;
    end else begin
      v_q <= v_d;
      if (cfg_we_i) thr_q <= cfg_data_i;
    end
  end

  ftb_front u_front (
    .clk_i (clk_i),
    .en_i  (rdy[OG0-1:0]),
    .thr_i (thr_q),
    .in_i  (in_data_i),
    .fr_o  (fr)
  );

  ftb_ortho u_ortho (
    .clk_i (clk_i),
    .en_i  (rdy[SQ0-1:OG0]),
    .fr_i  (fr),
    .og_o  (og)
  );

  ftb_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (rdy[DV0-1:SQ0]),
    .og_i  (og),
    .sq_o  (sq)
  );

  ftb_div u_div (
    .clk_i (clk_i),
    .en_i  (rdy[NS-2:DV0]),
    .sq_i  (sq),
    .dv_o  (dv)
  );

  always_comb begin
    logic [OW-1:0] tc [3];
    for (int i = 0; i < 3; i++) begin
      if (dv.zero) tc[i] = '0;
      else tc[i] = dv.ps[i] ? -OW'(dv.q[i]) : OW'(dv.q[i]);
    end
    out_d.tangent_x           = tc[0];
    out_d.tangent_y           = tc[1];
    out_d.tangent_z           = tc[2];
    out_d.handedness_negative = dv.hand;
    out_d.degenerate_uv       = dv.degen;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) out_q <= out_d;
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NS-1];
  assign out_data_o  = out_q;

endmodule

// ===== sv/ftb_checker.sv =====
// ---------------------------------------------------------------------------
// ftb_checker
// Port-level checks of the tangent basis block, bound to the top level.
// ---------------------------------------------------------------------------
`include "face_tangent_basis_assert.svh"

module ftb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ftb_pkg::out_word_t out_data_o
);
  import ftb_pkg::*;

  logic tan_zero, rng_ok, big_ok;

  assign tan_zero = (out_data_o.tangent_x == '0) && (out_data_o.tangent_y == '0)
                    && (out_data_o.tangent_z == '0);
  assign rng_ok   = (out_data_o.tangent_x >= -16'sd16384) && (out_data_o.tangent_x <= 16'sd16384)
                    && (out_data_o.tangent_y >= -16'sd16384)
                    && (out_data_o.tangent_y <= 16'sd16384)
                    && (out_data_o.tangent_z >= -16'sd16384)
                    && (out_data_o.tangent_z <= 16'sd16384);
  assign big_ok   = (out_data_o.tangent_x >= 16'sd8192) || (out_data_o.tangent_x <= -16'sd8192)
                    || (out_data_o.tangent_y >= 16'sd8192)
                    || (out_data_o.tangent_y <= -16'sd8192)
                    || (out_data_o.tangent_z >= 16'sd8192)
                    || (out_data_o.tangent_z <= -16'sd8192);

  `FTB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `FTB_ASSERT_IMP(a_in_ready, clk_i, rst_ni, !out_valid_o || out_ready_i, in_ready_o)
  `FTB_ASSERT_IMP(a_unit_range, clk_i, rst_ni, out_valid_o, rng_ok)
  `FTB_ASSERT_IMP(a_zero_hand, clk_i, rst_ni, out_valid_o && tan_zero, !out_data_o.handedness_negative)
  `FTB_ASSERT_IMP(a_unit_len, clk_i, rst_ni, out_valid_o && !tan_zero, big_ok)

endmodule

bind face_tangent_basis ftb_checker u_ftb_checker (.*);
